// ----- hdl/swtm_pkg.sv -----
// Shared constants and types for the sliding window trimmed mean unit.
package swtm_pkg;

  localparam int WIN_MAX  = 64;
  localparam int IDX_W    = $clog2(WIN_MAX);
  localparam int CNT_W    = IDX_W + 1;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = SAMPLE_W + IDX_W;
  localparam int K_W      = 5;
  localparam int AVG_W    = 16;
  localparam int DCNT_W   = $clog2(SUM_W + 1);

  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_TRIM   = 1'b1;

  typedef struct packed {
    logic                remove;
    logic                insert;
    logic                shift;
    logic [CNT_W-1:0]    fill;
    logic [SAMPLE_W-1:0] old;
    logic [SAMPLE_W-1:0] value;
  } ctl_t;

endpackage

// ----- hdl/swtm_cell.sv -----
// One window cell: holds an arrival-order sample and a sorted-order sample.
module swtm_cell (
  input  logic                          clk,
  input  logic [swtm_pkg::IDX_W-1:0]    idx,
  input  swtm_pkg::ctl_t                ctl,
  input  logic [swtm_pkg::SAMPLE_W-1:0] prev_sorted,
  input  logic                          prev_gt,
  input  logic [swtm_pkg::SAMPLE_W-1:0] next_sorted,
  input  logic [swtm_pkg::SAMPLE_W-1:0] next_arrival,
  output logic [swtm_pkg::SAMPLE_W-1:0] sorted_val,
  output logic [swtm_pkg::SAMPLE_W-1:0] arrival_val,
  output logic                          gt
);
  import swtm_pkg::*;

  logic [SAMPLE_W-1:0] sorted_r, sorted_nxt;
  logic [SAMPLE_W-1:0] arrival_r, arrival_nxt;
  logic                valid;
  logic                at_fill;
  logic                ge;

  assign valid   = {1'b0, idx} < ctl.fill;
  assign at_fill = {1'b0, idx} == ctl.fill;
  assign ge      = valid && (sorted_r >= ctl.old);
  assign gt      = valid && (sorted_r > ctl.value);

  always_comb begin
    sorted_nxt  = sorted_r;
    arrival_nxt = arrival_r;
    if (ctl.remove && ge) begin
      sorted_nxt = next_sorted;
    end
    if (ctl.insert) begin
      if (prev_gt) begin
        sorted_nxt = prev_sorted;
      end else if (gt || at_fill) begin
        sorted_nxt = ctl.value;
      end
      if (at_fill) begin
        arrival_nxt = ctl.value;
      end else if (ctl.shift && valid) begin
        arrival_nxt = next_arrival;
      end
    end
  end

  always_ff @(posedge clk) begin
    sorted_r  <= sorted_nxt;
    arrival_r <= arrival_nxt;
  end

  assign sorted_val  = sorted_r;
  assign arrival_val = arrival_r;

endmodule

// ----- hdl/swtm_sum.sv -----
// Three-level registered adder tree over the masked sorted cells.
module swtm_sum (
  input  logic                                               clk,
  input  logic [swtm_pkg::WIN_MAX-1:0][swtm_pkg::SAMPLE_W-1:0] terms,
  output logic [swtm_pkg::SUM_W-1:0]                         total
);
  import swtm_pkg::*;

  localparam int L1_N = WIN_MAX / 4;
  localparam int L2_N = L1_N / 4;
  localparam int L1_W = SAMPLE_W + 2;
  localparam int L2_W = SAMPLE_W + 4;

  logic [L1_N-1:0][L1_W-1:0] l1_r, l1_nxt;
  logic [L2_N-1:0][L2_W-1:0] l2_r, l2_nxt;
  logic [SUM_W-1:0]          l3_r, l3_nxt;

  always_comb begin
    for (int i = 0; i < L1_N; i++) begin
      l1_nxt[i] = L1_W'(terms[4*i]) + L1_W'(terms[4*i+1]) +
                  L1_W'(terms[4*i+2]) + L1_W'(terms[4*i+3]);
    end
    for (int i = 0; i < L2_N; i++) begin
      l2_nxt[i] = L2_W'(l1_r[4*i]) + L2_W'(l1_r[4*i+1]) +
                  L2_W'(l1_r[4*i+2]) + L2_W'(l1_r[4*i+3]);
    end
    l3_nxt = '0;
    for (int i = 0; i < L2_N; i++) begin
      l3_nxt = l3_nxt + SUM_W'(l2_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    l1_r <= l1_nxt;
    l2_r <= l2_nxt;
    l3_r <= l3_nxt;
  end

  assign total = l3_r;

endmodule

// ----- hdl/swtm_div.sv -----
// Restoring divider, one quotient bit per cycle.
module swtm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [swtm_pkg::SUM_W-1:0]  dividend,
  input  logic [swtm_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [swtm_pkg::AVG_W-1:0]  quotient
);
  import swtm_pkg::*;

  logic [SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [SUM_W-1:0]  q_r, q_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dsr_r, dsr_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W:0]    trial;

  assign trial = {rem_r, dvd_r[SUM_W-1]};

  always_comb begin
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      q_nxt    = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = DCNT_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[SUM_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = CNT_W'(trial - {1'b0, dsr_r});
        q_nxt   = {q_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = CNT_W'(trial);
        q_nxt   = {q_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r[AVG_W-1:0];

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !$past(start) |-> rem_r < dsr_r) else $error("remainder overflow");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
`endif

endmodule

// ----- hdl/sliding_window_trimmed_mean_unit.sv -----
// Sliding window trimmed mean: top level with cell chain, sum tree and divider.
// Path from input transfer to output valid: output only when misconfigured; insert and output
//   while filling; insert, 3-level sum, 22-step divider and output when the sample fills the window;
//   a remove comes first once the window is full.
// Throughput: one item at a time; output stalls also hold off the next input transfer.
// Reset: synchronous active-low rst_n empties the window, m = 3, k = 1, no output pending.
module sliding_window_trimmed_mean_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [swtm_pkg::SAMPLE_W-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swtm_pkg::AVG_W-1:0]    out_average,
  output logic                          out_ready_res,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [swtm_pkg::CNT_W-1:0]    cfg_wdata
);
  import swtm_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REMOVE = 3'd1;
  localparam logic [2:0] ST_INSERT = 3'd2;
  localparam logic [2:0] ST_SUM    = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    m_r, m_nxt;
  logic [K_W-1:0]      k_r, k_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [SAMPLE_W-1:0] old_r, old_nxt;
  logic                shift_r, shift_nxt;
  logic [1:0]          scnt_r, scnt_nxt;
  logic [AVG_W-1:0]    res_avg_r, res_avg_nxt;
  logic                res_rdy_r, res_rdy_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic [AVG_W-1:0]    oavg_r, oavg_nxt;
  logic                ordy_r, ordy_nxt;

  logic                cfg_ok;
  logic [CNT_W-1:0]    k_ext;
  logic [CNT_W-1:0]    hi_bound;
  logic [CNT_W-1:0]    divisor;
  logic                in_xfer;
  logic                div_start;
  logic                div_done;
  logic [AVG_W-1:0]    div_q;
  logic [SUM_W-1:0]    total;
  ctl_t                ctl;

  logic [WIN_MAX-1:0][SAMPLE_W-1:0] sorted_w;
  logic [WIN_MAX-1:0][SAMPLE_W-1:0] arrival_w;
  logic [WIN_MAX-1:0]               gt_w;
  logic [WIN_MAX-1:0][SAMPLE_W-1:0] prev_sorted_w;
  logic [WIN_MAX-1:0]               prev_gt_w;
  logic [WIN_MAX-1:0][SAMPLE_W-1:0] next_sorted_w;
  logic [WIN_MAX-1:0][SAMPLE_W-1:0] next_arrival_w;
  logic [WIN_MAX-1:0][SAMPLE_W-1:0] terms;

  assign k_ext    = CNT_W'(k_r);
  assign cfg_ok   = (m_r >= CNT_W'(1)) && (m_r <= CNT_W'(WIN_MAX)) &&
                    ({k_ext[CNT_W-2:0], 1'b0} < m_r) && !k_ext[CNT_W-1];
  assign hi_bound = m_r - k_ext;
  assign divisor  = m_r - {k_ext[CNT_W-2:0], 1'b0};
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  assign ctl.remove = (state_r == ST_REMOVE);
  assign ctl.insert = (state_r == ST_INSERT);
  assign ctl.shift  = shift_r;
  assign ctl.fill   = fill_r;
  assign ctl.old    = old_r;
  assign ctl.value  = sample_r;

  genvar gi;
  generate
    for (gi = 0; gi < WIN_MAX; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign prev_sorted_w[gi] = '0;
        assign prev_gt_w[gi]     = 1'b0;
      end else begin : g_mid
        assign prev_sorted_w[gi] = sorted_w[gi-1];
        assign prev_gt_w[gi]     = gt_w[gi-1];
      end
      if (gi == WIN_MAX - 1) begin : g_last
        assign next_sorted_w[gi]  = sorted_w[gi];
        assign next_arrival_w[gi] = arrival_w[gi];
      end else begin : g_inner
        assign next_sorted_w[gi]  = sorted_w[gi+1];
        assign next_arrival_w[gi] = arrival_w[gi+1];
      end
      swtm_cell u_cell (
        .clk          (clk),
        .idx          (IDX_W'(gi)),
        .ctl          (ctl),
        .prev_sorted  (prev_sorted_w[gi]),
        .prev_gt      (prev_gt_w[gi]),
        .next_sorted  (next_sorted_w[gi]),
        .next_arrival (next_arrival_w[gi]),
        .sorted_val   (sorted_w[gi]),
        .arrival_val  (arrival_w[gi]),
        .gt           (gt_w[gi])
      );
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < WIN_MAX; i++) begin
      terms[i] = ((CNT_W'(i) >= k_ext) && (CNT_W'(i) < hi_bound)) ? sorted_w[i] : '0;
    end
  end

  swtm_sum u_sum (
    .clk   (clk),
    .terms (terms),
    .total (total)
  );

  assign div_start = (state_r == ST_SUM) && (scnt_r == 2'd3);

  swtm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt   = state_r;
    m_nxt       = m_r;
    k_nxt       = k_r;
    fill_nxt    = fill_r;
    sample_nxt  = sample_r;
    old_nxt     = old_r;
    shift_nxt   = shift_r;
    scnt_nxt    = scnt_r;
    res_avg_nxt = res_avg_r;
    res_rdy_nxt = res_rdy_r;
    ovalid_nxt  = ovalid_r && out_stall;
    oavg_nxt    = oavg_r;
    ordy_nxt    = ordy_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          sample_nxt  = in_sample;
          res_avg_nxt = '0;
          res_rdy_nxt = 1'b0;
          if (!cfg_ok) begin
            state_nxt = ST_OUT;
          end else if (fill_r == m_r) begin
            old_nxt   = arrival_w[0];
            shift_nxt = 1'b1;
            state_nxt = ST_REMOVE;
          end else begin
            shift_nxt = 1'b0;
            state_nxt = ST_INSERT;
          end
        end
      end
      ST_REMOVE: begin
        fill_nxt  = fill_r - 1'b1;
        state_nxt = ST_INSERT;
      end
      ST_INSERT: begin
        fill_nxt = fill_r + 1'b1;
        if (fill_nxt == m_r) begin
          scnt_nxt  = '0;
          state_nxt = ST_SUM;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_SUM: begin
        scnt_nxt = scnt_r + 1'b1;
        if (scnt_r == 2'd3) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_avg_nxt = div_q;
          res_rdy_nxt = 1'b1;
          state_nxt   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovalid_r || !out_stall) begin
          ovalid_nxt = 1'b1;
          oavg_nxt   = res_avg_r;
          ordy_nxt   = res_rdy_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      fill_nxt = '0;
      case (cfg_index)
        CFG_WINDOW: m_nxt = cfg_wdata;
        CFG_TRIM:   k_nxt = cfg_wdata[K_W-1:0];
        default:    m_nxt = m_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      m_r      <= CNT_W'(3);
      k_r      <= K_W'(1);
      fill_r   <= '0;
      ovalid_r <= 1'b0;
      shift_r  <= 1'b0;
      scnt_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      m_r      <= m_nxt;
      k_r      <= k_nxt;
      fill_r   <= fill_nxt;
      ovalid_r <= ovalid_nxt;
      shift_r  <= shift_nxt;
      scnt_r   <= scnt_nxt;
    end
    sample_r  <= sample_nxt;
    old_r     <= old_nxt;
    res_avg_r <= res_avg_nxt;
    res_rdy_r <= res_rdy_nxt;
    oavg_r    <= oavg_nxt;
    ordy_r    <= ordy_nxt;
  end

  assign out_valid     = ovalid_r;
  assign out_average   = oavg_r;
  assign out_ready_res = ordy_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WIN_MAX)) else $error("window fill overflow");
  a_remove_then_insert: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_REMOVE |=> state_r == ST_INSERT) else $error("remove not followed by insert");
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV) else $error("divider result outside divide step");
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT && res_rdy_r |-> fill_r == m_r) else $error("ready result with partial window");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the sliding window trimmed mean unit: queued driver, monitor and window predictor.
`timescale 1ns / 1ps
module tb_top;
  import swtm_pkg::*;

  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic             ready_res;
  } mean_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [AVG_W-1:0]    out_average;
  logic                out_ready_res;
  logic                cfg_we = 1'b0;
  logic                cfg_index = CFG_WINDOW;
  logic [CNT_W-1:0]    cfg_wdata = '0;

  logic [SAMPLE_W-1:0] pending_samples[$];
  mean_t               expected_means[$];
  logic [SAMPLE_W-1:0] arrival_q[$];
  logic [SAMPLE_W-1:0] sorted_q[$];
  int unsigned         win_len = 3;
  int unsigned         trim_k = 1;
  int unsigned         mismatches = 0;
  int unsigned         accepted_in = 0;
  int unsigned         idle_cycles = 0;
  int unsigned         burst_left = 0;
  int unsigned         gap_left = 0;
  int unsigned         hold_left = 0;
  logic                hold_done = 1'b0;

  sliding_window_trimmed_mean_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_average(out_average), .out_ready_res(out_ready_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic mean_t trimmed_mean(input logic [SAMPLE_W-1:0] s);
    mean_t r;
    logic [SAMPLE_W-1:0] old;
    int i;
    logic [31:0] sum;
    r = '0;
    if (win_len < 1 || win_len > WIN_MAX || 2 * trim_k >= win_len) return r;
    if (arrival_q.size() >= win_len) begin
      old = arrival_q[0];
      arrival_q.delete(0);
      for (i = 0; i < sorted_q.size(); i++) begin
        if (sorted_q[i] == old) begin
          sorted_q.delete(i);
          break;
        end
      end
    end
    arrival_q.insert(arrival_q.size(), s);
    i = 0;
    while (i < sorted_q.size() && sorted_q[i] <= s) i++;
    sorted_q.insert(i, s);
    if (arrival_q.size() == win_len) begin
      sum = 0;
      for (i = trim_k; i < win_len - trim_k; i++) sum += sorted_q[i];
      r.average = AVG_W'(sum / (win_len - 2 * trim_k));
      r.ready_res = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return SAMPLE_W'($urandom);
      1: return SAMPLE_W'($urandom_range(0, 7));
      2: return $urandom_range(0, 1) ? '1 : '0;
      default: return SAMPLE_W'($urandom_range(16'hFFF0, 16'hFFFF));
    endcase
  endfunction

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_valid <= 1'b1;
        in_sample <= pending_samples[0];
        pending_samples.delete(0);
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern with one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && accepted_in >= 600) begin
      hold_done <= 1'b1;
      hold_left <= 500;
      out_stall <= 1'b1;
    end else if ((accepted_in / 200) % 3 == 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= $urandom_range(0, 2) == 0;
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    mean_t got;
    mean_t want;
    logic  moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        expected_means.insert(expected_means.size(), trimmed_mean(in_sample));
        accepted_in <= accepted_in + 1;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        got.average = out_average;
        got.ready_res = out_ready_res;
        if (expected_means.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: average=%0d ready=%0b", got.average, got.ready_res);
        end else begin
          want = expected_means[0];
          expected_means.delete(0);
          if (got.average !== want.average || got.ready_res !== want.ready_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: average exp=%0d got=%0d ready exp=%0b got=%0b",
                       want.average, got.average, want.ready_res, got.ready_res);
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles > 4000) begin
        $display("[sliding_window_trimmed_mean_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [CNT_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WINDOW) win_len = data;
    else trim_k = data[K_W-1:0];
    arrival_q.delete();
    sorted_q.delete();
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_means.size() > 0)
      @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    repeat (n) pending_samples.insert(pending_samples.size(), pick_sample());
    drain();
  endtask

  initial begin
    int unsigned m;
    int unsigned k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes and duplicates under the reset setting
    pending_samples = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0005,
                        16'h0005, 16'h0005, 16'h0001, 16'h0005, 16'h8000, 16'h7FFF,
                        16'h5555, 16'hAAAA, 16'h0000, 16'h0000};
    drain();
    write_reg(CFG_WINDOW, 7'd64);
    write_reg(CFG_TRIM, 5'd31);
    run_random(160);
    write_reg(CFG_TRIM, 7'd0);
    run_random(150);
    write_reg(CFG_WINDOW, 7'd1);
    run_random(40);
    write_reg(CFG_WINDOW, 7'd0);
    run_random(20);
    write_reg(CFG_WINDOW, 7'd100);
    run_random(20);
    write_reg(CFG_WINDOW, 7'd4);
    write_reg(CFG_TRIM, 7'd2);
    run_random(20);
    write_reg(CFG_TRIM, 7'h61);
    run_random(60);
    repeat (14) begin
      m = $urandom_range(0, 3) == 0 ? $urandom_range(17, 64) : $urandom_range(3, 16);
      k = $urandom_range(0, (m - 1) / 2);
      write_reg(CFG_WINDOW, CNT_W'(m));
      write_reg(CFG_TRIM, CNT_W'(k) | ($urandom_range(0, 1) ? 7'h60 : 7'h00));
      run_random(90);
    end
    if (mismatches == 0) begin
      $display("[sliding_window_trimmed_mean_unit] OK");
    end else begin
      $display("[sliding_window_trimmed_mean_unit] ERROR");
    end
    $finish;
  end

endmodule
